### rtl/mlp_backprop_train_step_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for mlp_backprop_train_step
// Shared concurrent assertion forms, clocked on i_clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef MLP_BACKPROP_TRAIN_STEP_ASSERT_SVH
`define MLP_BACKPROP_TRAIN_STEP_ASSERT_SVH

// same-cycle implication
`define MLP_BP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mlp_backprop_train_step assertion failed");

// next-cycle implication
`define MLP_BP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mlp_backprop_train_step assertion failed");

`endif

### rtl/mlp_bp_pkg.sv
// ----------------------------------------------------------------------------
// mlp_bp_pkg
// Constants, types, saturation helpers and the sigmoid table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mlp_bp_pkg;

    localparam int HIDDEN_UNITS        = 2;
    localparam int SIGMOID_TABLE_DEPTH = 256;
    localparam int SIG_BITS            = $clog2(SIGMOID_TABLE_DEPTH);

    localparam int NUM_HW = 3 * HIDDEN_UNITS;
    localparam int NUM_OW = HIDDEN_UNITS + 1;
    localparam int NUM_W  = NUM_HW + NUM_OW;
    localparam int ADDR_W = $clog2(NUM_W);
    localparam int CNT_W  = $clog2(NUM_OW + 3);
    localparam int IDX_W  = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;

    localparam logic [1:0] REQ_INFER = 2'd0;
    localparam logic [1:0] REQ_TRAIN = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    localparam logic REG_LR  = 1'b0;
    localparam logic REG_THR = 1'b1;

    localparam logic [15:0] LR_RESET  = 16'd6554;
    localparam logic [15:0] THR_RESET = 16'd32768;

    typedef struct packed {
        logic [15:0] lr;
        logic [15:0] thr;
    } t_cfg;

    typedef logic [15:0] t_sig_table [SIGMOID_TABLE_DEPTH];

    function automatic longint unsigned udiv64(input longint unsigned n,
                                               input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic longint exp_neg_frac(input longint f30);
        longint          sum;
        longint unsigned term;
        sum  = 64'sd1 <<< 30;
        term = 64'd1 << 30;
        for (int k = 1; k <= 20; k++) begin
            term = udiv64((term * longint'(f30)) >> 30, longint'(k));
            if ((k % 2) == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
        end
        return sum;
    endfunction

    function automatic t_sig_table build_sig_table();
        t_sig_table tab;
        longint     em1;
        longint     u;
        longint     a;
        longint     e;
        longint     den;
        longint     num;
        longint     s;
        em1 = exp_neg_frac(64'sd1 <<< 30);
        for (int k = 0; k < SIGMOID_TABLE_DEPTH; k++) begin
            u = -64'sd524288 + longint'(udiv64(longint'(2 * k + 1) << 20,
                                               longint'(2 * SIGMOID_TABLE_DEPTH)));
            a = (u < 0) ? -u : u;
            e = exp_neg_frac((a & 64'hFFFF) <<< 14);
            for (int n = 0; n < 8; n++) begin
                if (n < (a >>> 16)) e = (e * em1) >>> 30;
            end
            den = (64'sd1 <<< 30) + e;
            num = (u >= 0) ? (64'sd1 <<< 30) : e;
            s   = longint'(udiv64(longint'((num <<< 16) + (den >>> 1)), longint'(den)));
            tab[k] = (s > 65535) ? 16'hFFFF : ((s < 0) ? 16'h0000 : s[15:0]);
        end
        return tab;
    endfunction

    localparam t_sig_table SIG_TABLE = build_sig_table();

    function automatic logic signed [19:0] sat_pre(input logic signed [43:0] v);
        if (v > 44'sd524287) return 20'sd524287;
        if (v < -44'sd524288) return -20'sd524288;
        return v[19:0];
    endfunction

    function automatic logic [15:0] sig_of(input logic signed [19:0] p);
        logic [19:0] off;
        off = {~p[19], p[18:0]};
        return SIG_TABLE[off[19 -: SIG_BITS]];
    endfunction

    function automatic logic signed [23:0] sat_w(input logic signed [25:0] v);
        if (v > 26'sd8388607) return 24'sd8388607;
        if (v < -26'sd8388608) return -24'sd8388608;
        return v[23:0];
    endfunction

endpackage

### rtl/mlp_bp_cfg.sv
// ----------------------------------------------------------------------------
// mlp_bp_cfg
// APB register file for the learning rate and the class threshold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlp_bp_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output mlp_bp_pkg::t_cfg  o_cfg
);

    logic [15:0] r_lr;
    logic [15:0] r_thr;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr  <= mlp_bp_pkg::LR_RESET;
            r_thr <= mlp_bp_pkg::THR_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                mlp_bp_pkg::REG_LR:  r_lr  <= pwdata[15:0];
                mlp_bp_pkg::REG_THR: r_thr <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            mlp_bp_pkg::REG_LR:  prdata = {16'd0, r_lr};
            mlp_bp_pkg::REG_THR: prdata = {16'd0, r_thr};
            default:             prdata = 32'd0;
        endcase
    end

    assign o_cfg.lr  = r_lr;
    assign o_cfg.thr = r_thr;

endmodule

### rtl/mlp_backprop_train_step.sv
// ----------------------------------------------------------------------------
// mlp_backprop_train_step
// 2-2-1 sigmoid perceptron with online backpropagation training.
// ----------------------------------------------------------------------------
// One item at a time: a new input is taken only in the idle state, after
// the previous result has been transferred. Each step is serialised by the
// single weight memory, with one registered read port and one write port,
// and by the one shared 25x25 multiplier through which every product of the
// update passes. Weights read as zero after reset until they are written.
`timescale 1ns / 1ps

module mlp_backprop_train_step (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] in_x0, [1] in_x1, [2] target_bit, [6:3] weight_index,
    // [30:7] weight_value, [31] zero
    input  logic [31:0] s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] net_output, [16] out_class, [32:17] sample_error, [39:33] zero
    output logic [39:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int H = mlp_bp_pkg::HIDDEN_UNITS;
    localparam int AW = mlp_bp_pkg::ADDR_W;
    localparam int CW = mlp_bp_pkg::CNT_W;
    localparam int IW = mlp_bp_pkg::IDX_W;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_HRD  = 5'd1;
    localparam logic [4:0] ST_HACC = 5'd2;
    localparam logic [4:0] ST_HSIG = 5'd3;
    localparam logic [4:0] ST_ORD  = 5'd4;
    localparam logic [4:0] ST_OMUL = 5'd5;
    localparam logic [4:0] ST_OACC = 5'd6;
    localparam logic [4:0] ST_OSIG = 5'd7;
    localparam logic [4:0] ST_T0   = 5'd8;
    localparam logic [4:0] ST_T1   = 5'd9;
    localparam logic [4:0] ST_T2   = 5'd10;
    localparam logic [4:0] ST_T3   = 5'd11;
    localparam logic [4:0] ST_T4   = 5'd12;
    localparam logic [4:0] ST_H0   = 5'd13;
    localparam logic [4:0] ST_H1   = 5'd14;
    localparam logic [4:0] ST_H2   = 5'd15;
    localparam logic [4:0] ST_H3   = 5'd16;
    localparam logic [4:0] ST_H4   = 5'd17;
    localparam logic [4:0] ST_U0   = 5'd18;
    localparam logic [4:0] ST_U1   = 5'd19;
    localparam logic [4:0] ST_V0   = 5'd20;
    localparam logic [4:0] ST_V1   = 5'd21;
    localparam logic [4:0] ST_OUT  = 5'd22;

    mlp_bp_pkg::t_cfg cfg;

    mlp_bp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    logic [4:0]               r_state;
    logic [4:0]               n_state;
    logic [1:0]               r_req;
    logic                     r_x0;
    logic                     r_x1;
    logic                     r_tbit;
    logic [CW-1:0]            r_i;
    logic [CW-1:0]            r_j;
    logic signed [43:0]       r_acc;
    logic [15:0]              r_y [H];
    logic signed [24:0]       r_steph [H];
    logic signed [24:0]       r_do;
    logic signed [24:0]       r_stepo;
    logic signed [24:0]       r_f1;
    logic signed [49:0]       r_prod;
    logic [15:0]              r_net;
    logic                     r_class;
    logic [15:0]              r_err;

    logic signed [23:0]       r_mem [mlp_bp_pkg::NUM_W];
    logic [mlp_bp_pkg::NUM_W-1:0] r_valid;
    logic signed [23:0]       r_rdata;

    logic                     in_xfer;
    logic                     we;
    logic [AW-1:0]            waddr;
    logic signed [23:0]       wdata;
    logic [AW-1:0]            raddr;
    logic signed [24:0]       mul_a;
    logic signed [24:0]       mul_b;
    logic signed [24:0]       prod_q16;
    logic signed [17:0]       diff;
    logic                     x_sel;
    logic [AW-1:0]            hid_addr;
    logic [AW-1:0]            out_addr;
    logic [IW-1:0]            yi;
    logic [IW-1:0]            yj;
    logic signed [24:0]       yext;
    logic [3:0]               in_widx;

    assign in_xfer  = s_axis_tvalid & s_axis_tready;
    assign in_widx  = s_axis_tdata[6:3];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {7'd0, r_err, r_class, r_net};

    assign prod_q16 = r_prod[40:16];
    assign diff     = $signed({1'b0, r_tbit, 16'd0}) - $signed({2'b00, r_net});
    assign x_sel    = (r_j == CW'(0)) ? r_x0 : ((r_j == CW'(1)) ? r_x1 : 1'b1);
    assign hid_addr = AW'(3 * int'(r_i) + int'(r_j));
    assign out_addr = AW'(mlp_bp_pkg::NUM_HW + int'(r_i));
    assign yi       = r_i[IW-1:0];
    assign yj       = r_j[IW-1:0];
    assign yext     = (r_j == CW'(H)) ? 25'sd65536 : $signed({9'd0, r_y[yj]});

    // memory address and write port
    always_comb begin
        raddr = hid_addr;
        we    = 1'b0;
        waddr = hid_addr;
        wdata = mlp_bp_pkg::sat_w(26'(r_rdata) + 26'(r_steph[yi]));
        case (r_state)
            ST_IDLE: begin
                waddr = in_widx[AW-1:0];
                wdata = $signed(s_axis_tdata[30:7]);
                we    = in_xfer && (s_axis_tuser == mlp_bp_pkg::REQ_WRITE)
                        && (in_widx < 4'(mlp_bp_pkg::NUM_W));
            end
            ST_ORD, ST_U0: raddr = AW'(mlp_bp_pkg::NUM_HW + int'(r_j));
            ST_H0:         raddr = out_addr;
            ST_U1: begin
                we    = 1'b1;
                waddr = AW'(mlp_bp_pkg::NUM_HW + int'(r_j));
                wdata = mlp_bp_pkg::sat_w(26'(r_rdata) + 26'(prod_q16));
            end
            ST_V1:   we = x_sel;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rdata <= r_valid[raddr] ? r_mem[raddr] : 24'sd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (we) begin
            r_valid[waddr] <= 1'b1;
        end
    end

    // shared multiplier operands
    always_comb begin
        mul_a = 25'sd0;
        mul_b = 25'sd0;
        case (r_state)
            ST_OMUL: begin
                mul_a = $signed({9'd0, r_y[yj]});
                mul_b = 25'(r_rdata);
            end
            ST_T0: begin
                mul_a = $signed({9'd0, r_net});
                mul_b = 25'sd65536 - $signed({9'd0, r_net});
            end
            ST_T1: begin
                mul_a = 25'(diff);
                mul_b = prod_q16;
            end
            ST_T2: begin
                mul_a = 25'(diff);
                mul_b = 25'(diff);
            end
            ST_T3: begin
                mul_a = $signed({9'd0, cfg.lr});
                mul_b = r_do;
            end
            ST_H0: begin
                mul_a = $signed({9'd0, r_y[yi]});
                mul_b = 25'sd65536 - $signed({9'd0, r_y[yi]});
            end
            ST_H1: begin
                mul_a = r_do;
                mul_b = 25'(r_rdata);
            end
            ST_H2: begin
                mul_a = prod_q16;
                mul_b = r_f1;
            end
            ST_H3: begin
                mul_a = $signed({9'd0, cfg.lr});
                mul_b = prod_q16;
            end
            ST_U0: begin
                mul_a = r_stepo;
                mul_b = yext;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = (s_axis_tuser == mlp_bp_pkg::REQ_WRITE) ? ST_OUT : ST_HRD;
                end
            end
            ST_HRD:  n_state = ST_HACC;
            ST_HACC: n_state = (r_j == CW'(2)) ? ST_HSIG : ST_HRD;
            ST_HSIG: n_state = (r_i == CW'(H - 1)) ? ST_ORD : ST_HRD;
            ST_ORD:  n_state = ST_OMUL;
            ST_OMUL: n_state = (r_j == CW'(H)) ? ST_OSIG : ST_OACC;
            ST_OACC: n_state = ST_ORD;
            ST_OSIG: n_state = (r_req == mlp_bp_pkg::REQ_TRAIN) ? ST_T0 : ST_OUT;
            ST_T0:   n_state = ST_T1;
            ST_T1:   n_state = ST_T2;
            ST_T2:   n_state = ST_T3;
            ST_T3:   n_state = ST_T4;
            ST_T4:   n_state = ST_H0;
            ST_H0:   n_state = ST_H1;
            ST_H1:   n_state = ST_H2;
            ST_H2:   n_state = ST_H3;
            ST_H3:   n_state = ST_H4;
            ST_H4:   n_state = (r_i == CW'(H - 1)) ? ST_U0 : ST_H0;
            ST_U0:   n_state = ST_U1;
            ST_U1:   n_state = (r_j == CW'(H)) ? ST_V0 : ST_U0;
            ST_V0:   n_state = ST_V1;
            ST_V1: begin
                if (r_j == CW'(2)) begin
                    n_state = (r_i == CW'(H - 1)) ? ST_OUT : ST_V0;
                end else begin
                    n_state = ST_V0;
                end
            end
            ST_OUT:  n_state = m_axis_tready ? ST_IDLE : ST_OUT;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_req   <= s_axis_tuser;
                r_x0    <= s_axis_tdata[0];
                r_x1    <= s_axis_tdata[1];
                r_tbit  <= s_axis_tdata[2];
                r_i     <= '0;
                r_j     <= '0;
                r_acc   <= '0;
                r_net   <= '0;
                r_class <= 1'b0;
                r_err   <= '0;
            end
            ST_HACC: begin
                if (x_sel) r_acc <= r_acc + 44'(r_rdata);
                r_j <= r_j + CW'(1);
            end
            ST_HSIG: begin
                r_y[yi] <= mlp_bp_pkg::sig_of(mlp_bp_pkg::sat_pre(r_acc));
                r_acc   <= '0;
                r_j     <= '0;
                if (r_i != CW'(H - 1)) r_i <= r_i + CW'(1);
            end
            ST_OMUL: begin
                if (r_j == CW'(H)) r_acc <= r_acc + (44'(r_rdata) <<< 16);
            end
            ST_OACC: begin
                r_acc <= r_acc + 44'(r_prod);
                r_j   <= r_j + CW'(1);
            end
            ST_OSIG: begin
                r_net   <= mlp_bp_pkg::sig_of(mlp_bp_pkg::sat_pre(r_acc >>> 16));
                r_class <= mlp_bp_pkg::sig_of(mlp_bp_pkg::sat_pre(r_acc >>> 16)) >= cfg.thr;
                r_i     <= '0;
                r_j     <= '0;
            end
            ST_T2: r_do <= prod_q16;
            ST_T3: r_err <= r_prod[32:17];
            ST_T4: r_stepo <= prod_q16;
            ST_H1: r_f1 <= prod_q16;
            ST_H4: begin
                r_steph[yi] <= prod_q16;
                if (r_i != CW'(H - 1)) r_i <= r_i + CW'(1);
                else r_i <= '0;
            end
            ST_U1: begin
                r_j <= (r_j == CW'(H)) ? '0 : r_j + CW'(1);
            end
            ST_V1: begin
                if (r_j == CW'(2)) begin
                    r_j <= '0;
                    r_i <= r_i + CW'(1);
                end else begin
                    r_j <= r_j + CW'(1);
                end
            end
            default: ;
        endcase
    end

`include "mlp_backprop_train_step_assert.svh"

    `MLP_BP_ASSERT_NOW(a_no_accept_while_busy, s_axis_tready, !m_axis_tvalid)
    `MLP_BP_ASSERT_NEXT(a_out_to_idle, m_axis_tvalid && m_axis_tready, r_state == ST_IDLE)
    `MLP_BP_ASSERT_NOW(a_write_in_range, we, waddr < AW'(mlp_bp_pkg::NUM_W))
    `MLP_BP_ASSERT_NOW(a_wreq_zero_result,
        m_axis_tvalid && (r_req == mlp_bp_pkg::REQ_WRITE), m_axis_tdata == 40'd0)

endmodule
